>>> src/pss_pkg.sv
// Package with the shared constants and types of the positional sequence store.
package pss_pkg;

    // Store geometry.
    localparam int CAPACITY  = 64;
    localparam int ITEM_BITS = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Port field widths.
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int ITEM_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int REM_W    = 7;
    localparam int LEN_W    = 7;

    // Request actions; the one unused code is handled as a failing request.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT_AT  = 3'd0,
        ACT_SORTED_INS = 3'd1,
        ACT_ERASE      = 3'd2,
        ACT_REMOVE_ALL = 3'd3,
        ACT_GET        = 3'd4,
        ACT_SET        = 3'd5,
        ACT_FIND       = 3'd6
    } t_action;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SCAN,
        ST_COMPACT,
        ST_GET,
        ST_DONE
    } t_state;

endpackage

>>> src/positional_sequence_store_unit.sv
// Positional sequence store: an ordered list in a single-port-write RAM under a sequencer.
//
// Usage:
//   The request channel (i_in_valid / o_in_stall) carries an action, a position
//   and an item. A request is taken when i_in_valid is high and o_in_stall is low.
//   The block works on one request at a time and holds o_in_stall high until the
//   result has been moved into the output register.
//   The result channel (o_out_valid / i_out_stall) carries ok, index, read_value,
//   removed and length. A held result waits in the output register while the
//   next request is already being taken and worked on.
// Flow: set and failing requests go straight to ST_DONE; get passes through ST_GET;
//   find scans the list in ST_SCAN; insert at shifts the entries from the top of the
//   list down to the position in ST_SHIFT_UP; sorted insert scans and then shifts;
//   erase and remove all copy the kept entries down in ST_COMPACT, starting at the
//   first position read.
//   Each step moves one entry through the RAM ports, so the loops set the rate, and
//   the block returns to ST_IDLE before it takes the next request.
// Reset (synchronous, active low) empties the list and drops any held result;
// the RAM contents are not cleared, since only entries below the count are read.
// While the receiver stalls, the result and its fields stay unchanged.
module positional_sequence_store_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [pss_pkg::ACTION_W-1:0] i_action,
    input  logic [pss_pkg::POS_W-1:0]  i_position,
    input  logic [pss_pkg::ITEM_W-1:0] i_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_ok,
    output logic [pss_pkg::INDEX_W-1:0] o_index,
    output logic [pss_pkg::ITEM_W-1:0] o_read_value,
    output logic [pss_pkg::REM_W-1:0]  o_removed,
    output logic [pss_pkg::LEN_W-1:0]  o_length
);
    import pss_pkg::*;

    // Entry storage and its registered read data.
    logic [ITEM_BITS-1:0] r_mem [CAPACITY];
    logic [ITEM_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [ITEM_BITS-1:0] mem_wdata;

    // Control state.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rv, n_rv;
    logic              r_pend, n_pend;
    logic              r_ovalid, n_ovalid;

    // Working registers of the current request.
    t_action           r_action, n_action;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [ITEM_BITS-1:0] r_item, n_item;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic [ADDR_W-1:0] r_ridx, n_ridx;
    logic [ADDR_W-1:0] r_dest, n_dest;

    // Pending result and output register.
    logic                 r_res_ok, n_res_ok;
    logic [INDEX_W-1:0]   r_res_index, n_res_index;
    logic [ITEM_BITS-1:0] r_res_rd, n_res_rd;
    logic [REM_W-1:0]     r_res_removed, n_res_removed;
    logic                 r_o_ok, n_o_ok;
    logic [INDEX_W-1:0]   r_o_index, n_o_index;
    logic [ITEM_W-1:0]    r_o_rd, n_o_rd;
    logic [REM_W-1:0]     r_o_removed, n_o_removed;
    logic [LEN_W-1:0]     r_o_length, n_o_length;

    logic                 in_accept;
    logic                 hit;
    logic                 keep;
    logic [CNT_W-1:0]     in_pos;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign in_pos    = CNT_W'(i_position);

    // RAM: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rv     <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rv     <= n_rv;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_action      <= n_action;
        r_pos         <= n_pos;
        r_item        <= n_item;
        r_ptr         <= n_ptr;
        r_wr          <= n_wr;
        r_ridx        <= n_ridx;
        r_dest        <= n_dest;
        r_res_ok      <= n_res_ok;
        r_res_index   <= n_res_index;
        r_res_rd      <= n_res_rd;
        r_res_removed <= n_res_removed;
        r_o_ok        <= n_o_ok;
        r_o_index     <= n_o_index;
        r_o_rd        <= n_o_rd;
        r_o_removed   <= n_o_removed;
        r_o_length    <= n_o_length;
    end

    // The shared compare: ordering for sorted insert, equality otherwise.
    always_comb begin
        if (r_action == ACT_SORTED_INS) begin
            hit = r_rv && (r_rdata >= r_item);
        end else begin
            hit = r_rv && (r_rdata == r_item);
        end
        keep = (r_action != ACT_REMOVE_ALL) || (r_rdata != r_item);
    end

    // Sequencer: next state, RAM control and result.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rv          = 1'b0;
        n_pend        = r_pend;
        n_ovalid      = r_ovalid;
        n_action      = r_action;
        n_pos         = r_pos;
        n_item        = r_item;
        n_ptr         = r_ptr;
        n_wr          = r_wr;
        n_ridx        = r_ridx;
        n_dest        = r_dest;
        n_res_ok      = r_res_ok;
        n_res_index   = r_res_index;
        n_res_rd      = r_res_rd;
        n_res_removed = r_res_removed;
        n_o_ok        = r_o_ok;
        n_o_index     = r_o_index;
        n_o_rd        = r_o_rd;
        n_o_removed   = r_o_removed;
        n_o_length    = r_o_length;
        mem_we        = 1'b0;
        mem_waddr     = r_ptr[ADDR_W-1:0];
        mem_raddr     = r_ptr[ADDR_W-1:0];
        mem_wdata     = r_item;

        // The output register empties when its result is taken.
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_action      = t_action'(i_action);
                    n_pos         = in_pos;
                    n_item        = i_item[ITEM_BITS-1:0];
                    n_res_ok      = 1'b0;
                    n_res_index   = '0;
                    n_res_rd      = '0;
                    n_res_removed = '0;
                    n_pend        = 1'b0;
                    n_state       = ST_DONE;
                    unique case (i_action)
                        ACT_INSERT_AT: begin
                            if (in_pos <= r_count && r_count < CNT_W'(CAPACITY)) begin
                                n_ptr   = r_count;
                                n_state = ST_SHIFT_UP;
                            end
                        end
                        ACT_SORTED_INS: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                n_ptr   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        ACT_ERASE: begin
                            if (in_pos < r_count) begin
                                n_ptr   = in_pos + 1'b1;
                                n_wr    = in_pos;
                                n_state = ST_COMPACT;
                            end
                        end
                        ACT_REMOVE_ALL: begin
                            n_ptr   = '0;
                            n_wr    = '0;
                            n_state = ST_COMPACT;
                        end
                        ACT_GET: begin
                            if (in_pos < r_count) begin
                                mem_raddr = in_pos[ADDR_W-1:0];
                                n_state   = ST_GET;
                            end
                        end
                        ACT_SET: begin
                            if (in_pos < r_count) begin
                                mem_we    = 1'b1;
                                mem_waddr = in_pos[ADDR_W-1:0];
                                mem_wdata = i_item[ITEM_BITS-1:0];
                                n_res_ok  = 1'b1;
                            end
                        end
                        ACT_FIND: begin
                            n_ptr   = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            // Move entries up one place from the top down, then drop the item in.
            ST_SHIFT_UP: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_dest;
                    mem_wdata = r_rdata;
                end
                if (r_ptr > r_pos) begin
                    mem_raddr = ADDR_W'(r_ptr - 1'b1);
                    n_dest    = r_ptr[ADDR_W-1:0];
                    n_pend    = 1'b1;
                    n_ptr     = r_ptr - 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_pos[ADDR_W-1:0];
                        mem_wdata = r_item;
                        n_count   = r_count + 1'b1;
                        n_res_ok  = 1'b1;
                        if (r_action == ACT_SORTED_INS) begin
                            n_res_index = r_pos[INDEX_W-1:0];
                        end
                        n_state = ST_DONE;
                    end
                end
            end

            // Walk the list from the front, one compare per cycle.
            ST_SCAN: begin
                if (hit) begin
                    if (r_action == ACT_SORTED_INS) begin
                        n_pos   = CNT_W'(r_ridx);
                        n_ptr   = r_count;
                        n_pend  = 1'b0;
                        n_state = ST_SHIFT_UP;
                    end else begin
                        n_res_ok    = 1'b1;
                        n_res_index = r_ridx;
                        n_state     = ST_DONE;
                    end
                end else if (r_ptr < r_count) begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_rv      = 1'b1;
                    n_ridx    = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr + 1'b1;
                end else if (!r_rv) begin
                    if (r_action == ACT_SORTED_INS) begin
                        n_pos   = r_count;
                        n_ptr   = r_count;
                        n_pend  = 1'b0;
                        n_state = ST_SHIFT_UP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end

            // Copy the kept entries down; the write slot never passes the read slot.
            ST_COMPACT: begin
                if (r_rv && keep) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[ADDR_W-1:0];
                    mem_wdata = r_rdata;
                    n_wr      = r_wr + 1'b1;
                end
                if (r_ptr < r_count) begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_rv      = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end else if (!r_rv) begin
                    n_count  = r_wr;
                    n_res_ok = 1'b1;
                    if (r_action == ACT_REMOVE_ALL) begin
                        n_res_removed = REM_W'(r_count - r_wr);
                    end
                    n_state = ST_DONE;
                end
            end

            // Read data of the addressed entry is ready.
            ST_GET: begin
                n_res_ok = 1'b1;
                n_res_rd = r_rdata;
                n_state  = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid    = 1'b1;
                    n_o_ok      = r_res_ok;
                    n_o_index   = r_res_index;
                    n_o_rd      = ITEM_W'(r_res_rd);
                    n_o_removed = r_res_removed;
                    n_o_length  = LEN_W'(r_count);
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_ok         = r_o_ok;
    assign o_index      = r_o_index;
    assign o_read_value = r_o_rd;
    assign o_removed    = r_o_removed;
    assign o_length     = r_o_length;

endmodule

>>> src/pss_checker.sv
// Port-level checker for the positional sequence store and its bind statement.
module pss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_ok,
    input logic [pss_pkg::INDEX_W-1:0]   o_index,
    input logic [pss_pkg::ITEM_W-1:0]    o_read_value,
    input logic [pss_pkg::REM_W-1:0]     o_removed,
    input logic [pss_pkg::LEN_W-1:0]     o_length
);
    import pss_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_ok) &&
        $stable(o_index) && $stable(o_read_value) && $stable(o_removed) &&
        $stable(o_length))
        else $error("held result changed under stall");

    // The count never exceeds the store capacity.
    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_length <= LEN_W'(CAPACITY))
        else $error("length beyond capacity");

    // A failed request reports no index, data or removal count.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_index == '0 && o_read_value == '0 &&
        o_removed == '0)
        else $error("failed request carries data");

    // An accepted request keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken without the block going busy");

    // Reset leaves the block idle with no result offered.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind positional_sequence_store_unit pss_checker u_pss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_ok         (o_ok),
    .o_index      (o_index),
    .o_read_value (o_read_value),
    .o_removed    (o_removed),
    .o_length     (o_length)
);
